FILE: sv/bptz_pkg.sv
// ----------------------------------------------------------------------------
// bptz_pkg
// Shared types, widths and helpers for the trailing-zero counter: the
// bundle that flows along the base-5 cell row and the divide-by-five step.
// ----------------------------------------------------------------------------
package bptz_pkg;

  // width of the result count
  localparam int COUNT_W = 36;

  // width of per-row base-5 counters (holds counts up to 31 cells)
  localparam int DIG_CNT_W = 5;

  // two bits of each stream moving one cell along per cycle
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [1:0] r_bits;
    logic [1:0] m_bits;
    logic [1:0] b_bits;
  } lane_t;

  // running totals handed from cell to cell with the last bit pair
  typedef struct packed {
    logic                 carry;
    logic [DIG_CNT_W-1:0] carries;
    logic                 zrun;
    logic [DIG_CNT_W-1:0] zeros;
  } tok_t;

  // one radix-4 step of a division by five
  typedef struct packed {
    logic [1:0] q;
    logic [2:0] rem;
  } div5_t;

  // shift two dividend bits into a remainder and take the quotient digit
  function automatic div5_t div5_step(input logic [2:0] rem, input logic [1:0] bits);
    logic [4:0] v;
    div5_t      res;
    v = {rem, bits};
    if (v >= 5'd15) begin
      res.q   = 2'd3;
      res.rem = 3'(v - 5'd15);
    end else if (v >= 5'd10) begin
      res.q   = 2'd2;
      res.rem = 3'(v - 5'd10);
    end else if (v >= 5'd5) begin
      res.q   = 2'd1;
      res.rem = 3'(v - 5'd5);
    end else begin
      res.q   = 2'd0;
      res.rem = v[2:0];
    end
    return res;
  endfunction

  // number of base-5 digits needed for any value below 2^bits
  function automatic int digits5(input int bits);
    longint unsigned lim;
    longint unsigned pw;
    int              k;
    lim = 64'd1 << bits;
    pw  = 64'd1;
    k   = 0;
    while (pw < lim) begin
      pw = pw * 64'd5;
      k++;
    end
    return k;
  endfunction

endpackage

FILE: sv/binomial_power_trailing_zeros.sv
// ----------------------------------------------------------------------------
// binomial_power_trailing_zeros
// Trailing decimal zeros of C(n,r) * base^exponent. Factors of two come from
// binary carry and trailing-zero tallies, factors of five from a row of
// base-5 digit cells fed two bits a cycle.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   n_value r_value base_value power_exponent
//   out      output     out_valid / out_ready zero_count bad_input
//
// Operand pairs stream through a row of D base-5 digit cells, D being the
// number of base-5 digits of a VALUE_BITS-bit value (14 at 32 bits), and
// the result then passes the multiply, add and output registers of the
// final stage. One transaction is in the row at a time; a new one is taken
// while a finished result waits in the output register.
// Synchronous reset clears control state only. A stalled output holds the
// arithmetic stages, and in_ready stays low until they are free.
// ----------------------------------------------------------------------------
module binomial_power_trailing_zeros #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [VALUE_BITS-1:0]        n_value,
  input  logic [VALUE_BITS-1:0]        r_value,
  input  logic [VALUE_BITS-1:0]        base_value,
  input  logic [VALUE_BITS-1:0]        power_exponent,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bptz_pkg::COUNT_W-1:0] zero_count,
  output logic                         bad_input
);
  import bptz_pkg::*;

  localparam int DIGITS = digits5(VALUE_BITS);
  localparam int BCW    = $clog2(VALUE_BITS + 1);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t          state;
  logic            accept;
  logic            done;
  logic            fin_busy;
  logic            bad_hold;
  logic [BCW-1:0]  carries2;
  logic [BCW-1:0]  tz2;
  logic [VALUE_BITS-1:0] exp_hold;
  lane_t           lanes [DIGITS+1];
  tok_t            toks  [DIGITS+1];

  assign in_ready = (state == S_IDLE) && !fin_busy;
  assign accept   = in_valid && in_ready;
  assign done     = lanes[DIGITS].valid && lanes[DIGITS].last;

  // transaction sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (accept) state <= S_RUN;
        S_RUN:   if (done) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // operand streaming
  bptz_feed #(.VALUE_BITS(VALUE_BITS)) u_feed (
    .clk            (clk),
    .rst            (rst),
    .start          (accept),
    .n_value        (n_value),
    .r_value        (r_value),
    .base_value     (base_value),
    .power_exponent (power_exponent),
    .lane           (lanes[0]),
    .carries2       (carries2),
    .tz2            (tz2),
    .exp_hold       (exp_hold),
    .bad_hold       (bad_hold)
  );

  // totals entering the lowest digit cell
  assign toks[0] = '{carry: 1'b0, carries: '0, zrun: 1'b1, zeros: '0};

  // base-5 digit cells
  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    bptz_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_in  (lanes[k]),
      .tok_in   (toks[k]),
      .lane_out (lanes[k+1]),
      .tok_out  (toks[k+1])
    );
  end

  // exponent scaling and result register
  bptz_final #(.VALUE_BITS(VALUE_BITS)) u_final (
    .clk        (clk),
    .rst        (rst),
    .start      (done),
    .bad        (bad_hold),
    .carries2   (carries2),
    .tz2        (tz2),
    .tok        (toks[DIGITS]),
    .exponent   (exp_hold),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .zero_count (zero_count),
    .bad_input  (bad_input),
    .busy       (fin_busy)
  );

endmodule

FILE: sv/bptz_cell.sv
// ----------------------------------------------------------------------------
// bptz_cell
// One base-5 digit position. Divides the incoming bit-pair streams of r,
// n-r and the base by five, passes the quotients on, and at the last pair
// folds its digit into the carry and zero-digit totals.
// ----------------------------------------------------------------------------
module bptz_cell (
  input  logic             clk,
  input  logic             rst,
  input  bptz_pkg::lane_t  lane_in,
  input  bptz_pkg::tok_t   tok_in,
  output bptz_pkg::lane_t  lane_out,
  output bptz_pkg::tok_t   tok_out
);
  import bptz_pkg::*;

  logic [2:0] rem_r;
  logic [2:0] rem_m;
  logic [2:0] rem_b;
  logic       vld;
  logic       lst;
  logic [1:0] qr;
  logic [1:0] qm;
  logic [1:0] qb;
  tok_t       tok;

  div5_t      dr;
  div5_t      dm;
  div5_t      db;
  logic [3:0] dsum;
  logic       cout;
  logic       bzero;

  // division steps for the three streams
  assign dr = div5_step(rem_r, lane_in.r_bits);
  assign dm = div5_step(rem_m, lane_in.m_bits);
  assign db = div5_step(rem_b, lane_in.b_bits);

  // base-5 addition of the final r and n-r digits
  assign dsum  = 4'(dr.rem) + 4'(dm.rem) + 4'(tok_in.carry);
  assign cout  = (dsum >= 4'd5);
  assign bzero = (db.rem == 3'd0);

  // remainders, cleared after the last pair of a transaction, and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rem_r <= '0;
      rem_m <= '0;
      rem_b <= '0;
      vld   <= 1'b0;
    end else begin
      vld <= lane_in.valid;
      if (lane_in.valid) begin
        if (lane_in.last) begin
          rem_r <= '0;
          rem_m <= '0;
          rem_b <= '0;
        end else begin
          rem_r <= dr.rem;
          rem_m <= dm.rem;
          rem_b <= db.rem;
        end
      end
    end
  end

  // quotient pairs and totals towards the next cell
  always_ff @(posedge clk) begin
    if (lane_in.valid) begin
      lst <= lane_in.last;
      qr  <= dr.q;
      qm  <= dm.q;
      qb  <= db.q;
      if (lane_in.last) begin
        tok.carry   <= cout;
        tok.carries <= tok_in.carries + DIG_CNT_W'(cout);
        tok.zrun    <= tok_in.zrun & bzero;
        tok.zeros   <= tok_in.zeros + DIG_CNT_W'(tok_in.zrun & bzero);
      end
    end
  end

  assign lane_out = '{valid: vld, last: lst, r_bits: qr, m_bits: qm, b_bits: qb};
  assign tok_out  = tok;

endmodule

FILE: sv/bptz_feed.sv
// ----------------------------------------------------------------------------
// bptz_feed
// Captures a transaction, forms n-r and the validity check, and streams the
// operands two bits a cycle, most significant first, into the cell row.
// Binary carry count and trailing zeros of the base are tallied on the way.
// ----------------------------------------------------------------------------
module bptz_feed #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [VALUE_BITS-1:0]                n_value,
  input  logic [VALUE_BITS-1:0]                r_value,
  input  logic [VALUE_BITS-1:0]                base_value,
  input  logic [VALUE_BITS-1:0]                power_exponent,
  output bptz_pkg::lane_t                      lane,
  output logic [$clog2(VALUE_BITS+1)-1:0]      carries2,
  output logic [$clog2(VALUE_BITS+1)-1:0]      tz2,
  output logic [VALUE_BITS-1:0]                exp_hold,
  output logic                                 bad_hold
);
  import bptz_pkg::*;

  localparam int SW    = VALUE_BITS + (VALUE_BITS % 2);
  localparam int PAIRS = SW / 2;
  localparam int PC_W  = $clog2(PAIRS + 1);
  localparam int BCW   = $clog2(VALUE_BITS + 1);
  localparam int AW    = BCW + 1;

  logic [SW-1:0]   n_sh;
  logic [SW-1:0]   r_sh;
  logic [SW-1:0]   m_sh;
  logic [SW-1:0]   b_sh;
  logic [PC_W-1:0] left;
  logic            busy;
  logic [AW-1:0]   acc_rm;
  logic [AW-1:0]   acc_n;
  logic [BCW-1:0]  run;

  function automatic logic [1:0] pc2(input logic [1:0] x);
    return {1'b0, x[1]} + {1'b0, x[0]};
  endfunction

  // pair counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (start) begin
      busy <= 1'b1;
      left <= PC_W'(PAIRS);
    end else if (busy) begin
      left <= left - PC_W'(1);
      if (left == PC_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // operand shifters and tallies
  always_ff @(posedge clk) begin
    if (start) begin
      n_sh     <= SW'(n_value);
      r_sh     <= SW'(r_value);
      m_sh     <= SW'(n_value - r_value);
      b_sh     <= SW'(base_value);
      exp_hold <= power_exponent;
      bad_hold <= (r_value > n_value) || (base_value == '0);
      acc_rm   <= '0;
      acc_n    <= '0;
      run      <= '0;
    end else if (busy) begin
      n_sh   <= {n_sh[SW-3:0], 2'b00};
      r_sh   <= {r_sh[SW-3:0], 2'b00};
      m_sh   <= {m_sh[SW-3:0], 2'b00};
      b_sh   <= {b_sh[SW-3:0], 2'b00};
      acc_rm <= acc_rm + AW'(pc2(r_sh[SW-1:SW-2])) + AW'(pc2(m_sh[SW-1:SW-2]));
      acc_n  <= acc_n + AW'(pc2(n_sh[SW-1:SW-2]));
      case (b_sh[SW-1:SW-2])
        2'b00:   run <= run + BCW'(2);
        2'b10:   run <= BCW'(1);
        default: run <= '0;
      endcase
    end
  end

  assign lane = '{valid:  busy,
                  last:   busy && (left == PC_W'(1)),
                  r_bits: r_sh[SW-1:SW-2],
                  m_bits: m_sh[SW-1:SW-2],
                  b_bits: b_sh[SW-1:SW-2]};

  // carries of r + (n-r) in binary: popcount(r) + popcount(n-r) - popcount(n)
  assign carries2 = BCW'(acc_rm - acc_n);
  assign tz2      = run;

endmodule

FILE: sv/bptz_final.sv
// ----------------------------------------------------------------------------
// bptz_final
// Scales the base multiplicities by the exponent, adds the binomial parts,
// takes the smaller total with saturation and holds it in the output register.
// ----------------------------------------------------------------------------
module bptz_final #(
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               bad,
  input  logic [$clog2(VALUE_BITS+1)-1:0]    carries2,
  input  logic [$clog2(VALUE_BITS+1)-1:0]    tz2,
  input  bptz_pkg::tok_t                     tok,
  input  logic [VALUE_BITS-1:0]              exponent,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [bptz_pkg::COUNT_W-1:0]       zero_count,
  output logic                               bad_input,
  output logic                               busy
);
  import bptz_pkg::*;

  localparam int BCW = $clog2(VALUE_BITS + 1);
  localparam int MW  = (BCW > DIG_CNT_W) ? BCW : DIG_CNT_W;
  localparam int PW  = VALUE_BITS + MW;
  localparam int TW  = PW + 1;

  logic                 m_valid;
  logic [PW-1:0]        p2;
  logic [PW-1:0]        p5;
  logic [BCW-1:0]       c2;
  logic [DIG_CNT_W-1:0] c5;
  logic                 m_bad;
  logic                 a_valid;
  logic [TW-1:0]        t2;
  logic [TW-1:0]        t5;
  logic                 a_bad;

  logic                 out_free;
  logic                 a_adv;
  logic                 m_adv;
  logic [TW-1:0]        mn;
  logic [COUNT_W-1:0]   cnt_sat;

  assign out_free = !out_valid || out_ready;
  assign a_adv    = a_valid && out_free;
  assign m_adv    = m_valid && (!a_valid || a_adv);
  assign busy     = m_valid || a_valid;

  // smaller total, clamped to the count width
  assign mn = (t2 < t5) ? t2 : t5;
  if (TW > COUNT_W) begin : g_sat
    assign cnt_sat = (|mn[TW-1:COUNT_W]) ? {COUNT_W{1'b1}} : mn[COUNT_W-1:0];
  end else begin : g_ext
    assign cnt_sat = COUNT_W'(mn);
  end

  // stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        m_valid <= 1'b1;
      end else if (m_adv) begin
        m_valid <= 1'b0;
      end
      if (m_adv) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // multiply, add, select
  always_ff @(posedge clk) begin
    if (start) begin
      p2    <= PW'(tz2) * PW'(exponent);
      p5    <= PW'(tok.zeros) * PW'(exponent);
      c2    <= carries2;
      c5    <= tok.carries;
      m_bad <= bad;
    end
    if (m_adv) begin
      t2    <= TW'(p2) + TW'(c2);
      t5    <= TW'(p5) + TW'(c5);
      a_bad <= m_bad;
    end
    if (a_adv) begin
      zero_count <= a_bad ? '0 : cnt_sat;
      bad_input  <= a_bad;
    end
  end

endmodule
